// ===== sv/cstp_pkg.sv =====
// shared constants, types and controller/datapath interface structs for the call-stack profiler
package cstp_pkg;

    // sizes
    localparam int NUM_FUNCS   = 16;
    localparam int STACK_DEPTH = 32;
    localparam int FUNC_W      = 4;
    localparam int TS_W        = 32;
    localparam int CALLS_W     = 32;
    localparam int TICKS_W     = 48;
    localparam int DEPTH_W     = 6;

    localparam int FUNC_AW     = $clog2(NUM_FUNCS);
    localparam int STACK_AW    = $clog2(STACK_DEPTH);
    localparam int LEVEL_W     = $clog2(STACK_DEPTH + 1);

    // stream packing
    localparam int IN_FIELDS_W  = FUNC_W + TS_W;
    localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = FUNC_W + CALLS_W + 2 * TICKS_W + 1;
    localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_PAD_W    = OUT_DATA_W - OUT_FIELDS_W;

    // event kinds
    localparam logic OP_ENTER = 1'b0;
    localparam logic OP_EXIT  = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_FETCH,
        S_SELF,
        S_CALLER,
        S_REPORT
    } state_t;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [TS_W-1:0]   start;
    } stk_entry_t;

    // controller to datapath
    typedef struct packed {
        logic               latch_in;
        logic               do_enter;
        logic               do_pop;
        logic               do_fetch;
        logic               do_self;
        logic               do_caller;
        logic               load_rec;
        logic               rec_last;
        logic [FUNC_AW-1:0] rpt_idx;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_exit;
        logic exit_ok;
        logic level_zero;
        logic out_free;
    } sts_t;

endpackage

// ===== sv/call_stack_time_profiler.sv =====
// call-stack time profiler top level: controller and datapath
// enter event: latched in S_IDLE, pushed in S_EXEC; exit inside a nested call: S_EXEC, S_FETCH, S_SELF, S_CALLER
// outermost exit: S_EXEC, S_FETCH, S_SELF, then one record per function (16), one per cycle while m_tready holds
// the single-port call stack memory with registered read and one table access per cycle set these steps
// a new event is taken while the final record still waits in the output register
// reset: synchronous active-low aresetn clears stack level, tables, overflow flag; enable set to 1
module call_stack_time_profiler (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic                                cfg_wdata,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // func_id [3:0], timestamp [35:4], zero pad above
    input  logic [cstp_pkg::IN_DATA_W-1:0]      s_tdata,
    // op [0]
    input  logic [0:0]                          s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // rec_func [3:0], call_count [35:4], self_ticks [83:36], total_ticks [131:84],
    // overflow_seen [132], zero pad above
    output logic [cstp_pkg::OUT_DATA_W-1:0]     m_tdata,
    output logic                                m_tlast
);

    cstp_pkg::cmd_t cmd;
    cstp_pkg::sts_t sts;

    // sequencing
    cstp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // storage and arithmetic
    cstp_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd       (cmd),
        .sts       (sts),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

// ===== sv/cstp_ctrl.sv =====
// controller state machine: event sequencing and report walk
module cstp_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  cstp_pkg::sts_t  sts,
    output cstp_pkg::cmd_t  cmd
);

    cstp_pkg::state_t               state_reg, state_next;
    logic [cstp_pkg::FUNC_AW-1:0]   idx_reg, idx_next;
    logic                           idx_last;

    assign idx_last = (idx_reg == cstp_pkg::FUNC_AW'(cstp_pkg::NUM_FUNCS - 1));

    // state and report counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= cstp_pkg::S_IDLE;
            idx_reg   <= '0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        case (state_reg)
            cstp_pkg::S_IDLE: begin
                if (s_tvalid) state_next = cstp_pkg::S_EXEC;
            end
            cstp_pkg::S_EXEC: begin
                if (sts.is_exit && sts.exit_ok) state_next = cstp_pkg::S_FETCH;
                else state_next = cstp_pkg::S_IDLE;
            end
            cstp_pkg::S_FETCH: begin
                state_next = cstp_pkg::S_SELF;
            end
            cstp_pkg::S_SELF: begin
                if (sts.level_zero) begin
                    state_next = cstp_pkg::S_REPORT;
                    idx_next   = '0;
                end else begin
                    state_next = cstp_pkg::S_CALLER;
                end
            end
            cstp_pkg::S_CALLER: begin
                state_next = cstp_pkg::S_IDLE;
            end
            cstp_pkg::S_REPORT: begin
                if (sts.out_free) begin
                    idx_next = idx_reg + cstp_pkg::FUNC_AW'(1);
                    if (idx_last) state_next = cstp_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = cstp_pkg::S_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        cmd         = '0;
        cmd.rpt_idx = idx_reg;
        cmd.rec_last = idx_last;
        s_tready    = 1'b0;
        case (state_reg)
            cstp_pkg::S_IDLE: begin
                s_tready     = 1'b1;
                cmd.latch_in = s_tvalid;
            end
            cstp_pkg::S_EXEC: begin
                cmd.do_enter = !sts.is_exit;
                cmd.do_pop   = sts.is_exit && sts.exit_ok;
            end
            cstp_pkg::S_FETCH:  cmd.do_fetch  = 1'b1;
            cstp_pkg::S_SELF:   cmd.do_self   = 1'b1;
            cstp_pkg::S_CALLER: cmd.do_caller = 1'b1;
            cstp_pkg::S_REPORT: cmd.load_rec  = sts.out_free;
            default: begin
                cmd.do_enter = 1'b0;
            end
        endcase
    end

    // a record is only loaded into a free output register
    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_rec |-> sts.out_free)
        else $error("record loaded while output register busy");

    // the final record ends the report walk
    a_last_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.load_rec && cmd.rec_last) |=> (state_reg == cstp_pkg::S_IDLE))
        else $error("report walk did not end after final record");

    // a pop always leads to the fetch of the popped entry
    a_pop_fetch: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.do_pop |=> cmd.do_fetch)
        else $error("pop not followed by fetch");

endmodule

// ===== sv/cstp_datapath.sv =====
// datapath: call stack memory, per-function tables, elapsed time and output register
module cstp_datapath (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic                                cfg_wdata,
    input  logic [cstp_pkg::IN_DATA_W-1:0]      s_tdata,
    input  logic [0:0]                          s_tuser,
    input  cstp_pkg::cmd_t                      cmd,
    output cstp_pkg::sts_t                      sts,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [cstp_pkg::OUT_DATA_W-1:0]     m_tdata,
    output logic                                m_tlast
);

    // latched event
    logic                               op_reg;
    logic [cstp_pkg::FUNC_W-1:0]        fid_reg;
    logic [cstp_pkg::TS_W-1:0]          ts_reg;

    // control state
    logic                               enable_reg;
    logic                               overflow_reg;
    logic [cstp_pkg::LEVEL_W-1:0]       level_reg, level_next;
    logic [cstp_pkg::LEVEL_W-1:0]       level_m1;

    // call stack memory
    cstp_pkg::stk_entry_t               stack_mem [cstp_pkg::STACK_DEPTH];
    cstp_pkg::stk_entry_t               rd_data_reg;
    logic                               rd_en;
    logic [cstp_pkg::STACK_AW-1:0]      rd_addr;
    logic                               wr_en;
    cstp_pkg::stk_entry_t               wr_data;

    // popped function and its elapsed time
    logic [cstp_pkg::FUNC_AW-1:0]       f_reg;
    logic [cstp_pkg::TS_W-1:0]          elapsed_reg;
    logic [cstp_pkg::TICKS_W-1:0]       elapsed_ext;

    // per-function tables
    logic [cstp_pkg::CALLS_W-1:0]       calls_reg [cstp_pkg::NUM_FUNCS];
    logic [cstp_pkg::TICKS_W-1:0]       self_reg  [cstp_pkg::NUM_FUNCS];
    logic [cstp_pkg::TICKS_W-1:0]       total_reg [cstp_pkg::NUM_FUNCS];
    logic [cstp_pkg::DEPTH_W-1:0]       depth_reg [cstp_pkg::NUM_FUNCS];
    logic [cstp_pkg::FUNC_AW-1:0]       tbl_addr;
    logic [cstp_pkg::CALLS_W-1:0]       calls_rd, calls_next;
    logic [cstp_pkg::TICKS_W-1:0]       self_rd, self_next;
    logic [cstp_pkg::TICKS_W-1:0]       total_rd, total_next;
    logic [cstp_pkg::DEPTH_W-1:0]       depth_rd, depth_next;
    logic                               calls_we, self_we, total_we, depth_we;

    // enter checks
    logic                               fid_ok;
    logic                               stack_full;
    logic                               enter_ok;

    // output register
    logic                               m_tvalid_reg;
    logic [cstp_pkg::FUNC_W-1:0]        rec_func_reg;
    logic [cstp_pkg::CALLS_W-1:0]       rec_calls_reg;
    logic [cstp_pkg::TICKS_W-1:0]       rec_self_reg;
    logic [cstp_pkg::TICKS_W-1:0]       rec_total_reg;
    logic                               rec_ovf_reg;
    logic                               rec_last_reg;

    assign level_m1    = level_reg - cstp_pkg::LEVEL_W'(1);
    assign fid_ok      = ({1'b0, fid_reg} < (cstp_pkg::FUNC_W + 1)'(cstp_pkg::NUM_FUNCS));
    assign stack_full  = (level_reg >= cstp_pkg::LEVEL_W'(cstp_pkg::STACK_DEPTH));
    assign enter_ok    = fid_ok && !stack_full;
    assign elapsed_ext = {{(cstp_pkg::TICKS_W - cstp_pkg::TS_W){1'b0}}, elapsed_reg};

    // status to controller
    assign sts.is_exit    = (op_reg == cstp_pkg::OP_EXIT);
    assign sts.exit_ok    = enable_reg && (level_reg != '0);
    assign sts.level_zero = (level_reg == '0);
    assign sts.out_free   = !m_tvalid_reg || m_tready;

    // event capture and configuration
    always_ff @(posedge aclk) begin
        if (cmd.latch_in) begin
            op_reg  <= s_tuser[0];
            fid_reg <= s_tdata[cstp_pkg::FUNC_W-1:0];
            ts_reg  <= s_tdata[cstp_pkg::FUNC_W +: cstp_pkg::TS_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg <= 1'b1;
        end else if (cfg_we) begin
            enable_reg <= cfg_wdata;
        end
    end

    // stack level and overflow flag
    always_comb begin
        level_next = level_reg;
        if (cmd.do_enter && enter_ok) level_next = level_reg + cstp_pkg::LEVEL_W'(1);
        else if (cmd.do_pop) level_next = level_m1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            level_reg    <= '0;
            overflow_reg <= 1'b0;
        end else begin
            level_reg <= level_next;
            if (cmd.do_enter && fid_ok && stack_full) overflow_reg <= 1'b1;
        end
    end

    // stack memory: push at level, read the entry below the level
    assign wr_en         = cmd.do_enter && enter_ok;
    assign wr_data.func  = fid_reg;
    assign wr_data.start = ts_reg;
    assign rd_en         = cmd.do_pop || cmd.do_fetch;
    assign rd_addr       = level_m1[cstp_pkg::STACK_AW-1:0];

    always_ff @(posedge aclk) begin
        if (wr_en) stack_mem[level_reg[cstp_pkg::STACK_AW-1:0]] <= wr_data;
        if (rd_en) rd_data_reg <= stack_mem[rd_addr];
    end

    // popped entry and elapsed ticks
    always_ff @(posedge aclk) begin
        if (cmd.do_fetch) begin
            f_reg       <= rd_data_reg.func[cstp_pkg::FUNC_AW-1:0];
            elapsed_reg <= ts_reg - rd_data_reg.start;
        end
    end

    // table address and read
    always_comb begin
        if (cmd.do_enter) tbl_addr = fid_reg[cstp_pkg::FUNC_AW-1:0];
        else if (cmd.do_self) tbl_addr = f_reg;
        else if (cmd.do_caller) tbl_addr = rd_data_reg.func[cstp_pkg::FUNC_AW-1:0];
        else tbl_addr = cmd.rpt_idx;
    end

    assign calls_rd = calls_reg[tbl_addr];
    assign self_rd  = self_reg[tbl_addr];
    assign total_rd = total_reg[tbl_addr];
    assign depth_rd = depth_reg[tbl_addr];

    // table update values
    always_comb begin
        calls_we   = 1'b0;
        self_we    = 1'b0;
        total_we   = 1'b0;
        depth_we   = 1'b0;
        calls_next = calls_rd;
        self_next  = self_rd;
        total_next = total_rd;
        depth_next = depth_rd;
        if (cmd.do_enter && enter_ok) begin
            calls_we   = 1'b1;
            depth_we   = 1'b1;
            calls_next = calls_rd + cstp_pkg::CALLS_W'(1);
            depth_next = depth_rd + cstp_pkg::DEPTH_W'(1);
        end else if (cmd.do_self) begin
            self_we    = 1'b1;
            self_next  = self_rd + elapsed_ext;
            total_we   = (depth_rd == cstp_pkg::DEPTH_W'(1));
            total_next = total_rd + elapsed_ext;
            depth_we   = (depth_rd != '0);
            depth_next = depth_rd - cstp_pkg::DEPTH_W'(1);
        end else if (cmd.do_caller) begin
            self_we   = 1'b1;
            self_next = self_rd - elapsed_ext;
        end else if (cmd.load_rec) begin
            calls_we   = 1'b1;
            self_we    = 1'b1;
            total_we   = 1'b1;
            calls_next = '0;
            self_next  = '0;
            total_next = '0;
        end
    end

    // table registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < cstp_pkg::NUM_FUNCS; i++) begin
                calls_reg[i] <= '0;
                self_reg[i]  <= '0;
                total_reg[i] <= '0;
                depth_reg[i] <= '0;
            end
        end else begin
            if (calls_we) calls_reg[tbl_addr] <= calls_next;
            if (self_we)  self_reg[tbl_addr]  <= self_next;
            if (total_we) total_reg[tbl_addr] <= total_next;
            if (depth_we) depth_reg[tbl_addr] <= depth_next;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.load_rec) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_rec) begin
            rec_func_reg  <= cstp_pkg::FUNC_W'(cmd.rpt_idx);
            rec_calls_reg <= calls_rd;
            rec_self_reg  <= self_rd;
            rec_total_reg <= total_rd;
            rec_ovf_reg   <= overflow_reg;
            rec_last_reg  <= cmd.rec_last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tlast  = rec_last_reg;
    assign m_tdata  = {{cstp_pkg::OUT_PAD_W{1'b0}}, rec_ovf_reg, rec_total_reg,
                       rec_self_reg, rec_calls_reg, rec_func_reg};

    // stack level stays within the stack
    a_level_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        level_reg <= cstp_pkg::LEVEL_W'(cstp_pkg::STACK_DEPTH))
        else $error("stack level beyond stack depth");

    // a pop never underflows the stack
    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.do_pop |-> (level_reg != '0) && enable_reg)
        else $error("pop on empty stack or while disabled");

    // a loaded record is presented in the next cycle
    a_rec_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_rec |=> m_tvalid_reg)
        else $error("loaded record not presented");

endmodule
